// File: hw/rtl/smrd_pkg.sv
// Shared types and constants for the secure module response deframer.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package smrd_pkg;

    // Framing constants.
    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam int BUFFER_BYTES = 1024;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int INDEX_W = 11;
    localparam int POLL_W = 16;
    localparam int LEN_LIMIT_W = 11;
    localparam int TOTAL_W = 17;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Configuration reset values.
    localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 16'd50000;
    localparam logic [LEN_LIMIT_W-1:0] LENGTH_LIMIT_RESET = 11'd1023;

    // Register map, selected by paddr[2].
    typedef enum logic {
        REG_POLL_LIMIT   = 1'b0,
        REG_LENGTH_LIMIT = 1'b1
    } t_reg_index;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_OK      = 3'd1,
        ST_CSUM    = 3'd2,
        ST_BADLEN  = 3'd3,
        ST_TIMEOUT = 3'd4
    } t_status;

    // Deframer phase, one-hot.
    typedef enum logic [2:0] {
        PH_HUNT   = 3'b001,
        PH_HEADER = 3'b010,
        PH_BODY   = 3'b100
    } t_phase;

    // Configuration seen by the step unit.
    typedef struct packed {
        logic [POLL_W-1:0]      poll_limit;
        logic [LEN_LIMIT_W-1:0] length_limit;
    } t_cfg;

    // One result of the step unit.
    typedef struct packed {
        logic               valid;
        logic [BYTE_W-1:0]  frame_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               frame_end;
        t_status            status;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/secure_module_response_deframer.sv
// Path: a result passes the input register, then the result register, before it
// is shown and can transfer; a sync byte or a counted idle byte shows nothing.
// Throughput: one byte per cycle while the result register is free or being taken.
// Reset: synchronous, active low; clears phase, counters and both valid flags,
// and loads the configuration registers with their defaults.
`default_nettype none

module secure_module_response_deframer
    import smrd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_BYTES
)
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Byte input channel.
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [BYTE_W-1:0]  i_rx_byte,
    // Result output channel.
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [BYTE_W-1:0]       o_frame_byte,
    output logic [INDEX_W-1:0]      o_byte_index,
    output logic                    o_frame_end,
    output logic [2:0]              o_status,
    // Configuration port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_out_valid;
    t_result            r_out;
    t_cfg               r_cfg;
    t_result            w_result;
    logic               w_advance;
    logic               w_fire;
    logic               w_in_xfer;
    logic               w_cfg_write;
    t_reg_index         w_reg;

    // Handshake: the input register moves on when the result register is free.
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_byte <= i_rx_byte;
        end
    end

    smrd_step #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_enable  (w_fire),
        .i_rx_byte (r_in_byte),
        .i_cfg     (r_cfg),
        .o_result  (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_fire && w_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_result.valid) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_out.frame_byte;
    assign o_byte_index = r_out.byte_index;
    assign o_frame_end  = r_out.frame_end;
    assign o_status     = r_out.status;

    // Configuration registers.
    assign w_reg       = t_reg_index'(paddr[2]);
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign pready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_limit   <= POLL_LIMIT_RESET;
            r_cfg.length_limit <= LENGTH_LIMIT_RESET;
        end else if (w_cfg_write) begin
            unique case (w_reg)
                REG_POLL_LIMIT:   r_cfg.poll_limit   <= pwdata[POLL_W-1:0];
                REG_LENGTH_LIMIT: r_cfg.length_limit <= pwdata[LEN_LIMIT_W-1:0];
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (w_reg)
            REG_POLL_LIMIT:   prdata = PDATA_W'(r_cfg.poll_limit);
            REG_LENGTH_LIMIT: prdata = PDATA_W'(r_cfg.length_limit);
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/smrd_step.sv
// Deframer state and per-byte next-state logic.
// Depends on smrd_pkg; instantiated by secure_module_response_deframer.
`default_nettype none

module smrd_step
    import smrd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_BYTES
)
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_enable,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    input  wire t_cfg              i_cfg,
    output t_result                o_result
);

    t_phase               r_phase, n_phase;
    logic [INDEX_W-1:0]   r_position, n_position;
    logic [BYTE_W-1:0]    r_length_high, n_length_high;
    logic [INDEX_W-1:0]   r_remaining, n_remaining;
    logic [BYTE_W-1:0]    r_running_xor, n_running_xor;
    logic [POLL_W-1:0]    r_poll_count, n_poll_count;

    logic [TOTAL_W-1:0]   w_total;
    logic [POLL_W-1:0]    w_poll_inc;
    logic                 w_len_ok;

    // Body length from the header and the poll count after this byte.
    assign w_total = TOTAL_W'({r_length_high, i_rx_byte}) + TOTAL_W'(1);
    assign w_len_ok = (w_total < TOTAL_W'(i_cfg.length_limit)) &&
                      (w_total < TOTAL_W'(BUFFER_DEPTH));
    assign w_poll_inc = r_poll_count + POLL_W'(1);

    // Next state and result for one received byte.
    always_comb begin
        n_phase       = r_phase;
        n_position    = r_position;
        n_length_high = r_length_high;
        n_remaining   = r_remaining;
        n_running_xor = r_running_xor;
        n_poll_count  = r_poll_count;

        o_result            = '0;
        o_result.frame_byte = i_rx_byte;
        o_result.byte_index = r_position;
        o_result.status     = ST_BUSY;

        unique case (r_phase)
            PH_HEADER: begin
                o_result.valid = 1'b1;
                n_running_xor = r_running_xor ^ i_rx_byte;
                if (r_position == INDEX_W'(2)) begin
                    n_length_high = i_rx_byte;
                end
                if (r_position < INDEX_W'(3)) begin
                    n_position = r_position + INDEX_W'(1);
                end else if (w_len_ok) begin
                    n_remaining = w_total[INDEX_W-1:0];
                    n_position  = INDEX_W'(4);
                    n_phase     = PH_BODY;
                end else begin
                    n_phase            = PH_HUNT;
                    n_position         = '0;
                    o_result.frame_end = 1'b1;
                    o_result.status    = ST_BADLEN;
                end
            end
            PH_BODY: begin
                o_result.valid = 1'b1;
                if (r_remaining <= INDEX_W'(1)) begin
                    // Last byte carries the inverted XOR of the frame.
                    n_phase            = PH_HUNT;
                    n_position         = '0;
                    n_remaining        = '0;
                    o_result.frame_end = 1'b1;
                    if (i_rx_byte == ~r_running_xor) begin
                        n_poll_count    = '0;
                        o_result.status = ST_OK;
                    end else begin
                        o_result.status = ST_CSUM;
                    end
                end else begin
                    n_running_xor = r_running_xor ^ i_rx_byte;
                    n_remaining   = r_remaining - INDEX_W'(1);
                    n_position    = r_position + INDEX_W'(1);
                end
            end
            default: begin
                // Hunting; an illegal phase code also hunts.
                n_phase = PH_HUNT;
                if (i_rx_byte == SYNC_BYTE) begin
                    n_phase       = PH_HEADER;
                    n_position    = '0;
                    n_running_xor = '0;
                    n_length_high = '0;
                    n_remaining   = '0;
                end else if (w_poll_inc >= i_cfg.poll_limit) begin
                    n_poll_count        = '0;
                    o_result.valid      = 1'b1;
                    o_result.frame_byte = '0;
                    o_result.byte_index = '0;
                    o_result.frame_end  = 1'b1;
                    o_result.status     = ST_TIMEOUT;
                end else begin
                    n_poll_count = w_poll_inc;
                end
            end
        endcase
    end

    // State registers advance only when a byte is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_position    <= '0;
            r_length_high <= '0;
            r_remaining   <= '0;
            r_running_xor <= '0;
            r_poll_count  <= '0;
        end else if (i_enable) begin
            r_phase       <= n_phase;
            r_position    <= n_position;
            r_length_high <= n_length_high;
            r_remaining   <= n_remaining;
            r_running_xor <= n_running_xor;
            r_poll_count  <= n_poll_count;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/smrd_checker.sv
// Port-level checks for the secure module response deframer, with its bind.
// Depends on smrd_pkg; attaches to secure_module_response_deframer.
`default_nettype none

module smrd_checker
    import smrd_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [BYTE_W-1:0]  o_frame_byte,
    input wire logic [INDEX_W-1:0] o_byte_index,
    input wire logic               o_frame_end,
    input wire logic [2:0]         o_status
);

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frame_byte) &&
            $stable(o_byte_index) && $stable(o_frame_end) && $stable(o_status))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Frame end marks exactly the results with a final status.
    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_end == (o_status != ST_BUSY)))
        else $error("frame end disagrees with status");

    // A timeout carries a zero byte at index zero.
    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_TIMEOUT) |->
            (o_frame_byte == '0) && (o_byte_index == '0))
        else $error("timeout result not zeroed");

endmodule

bind secure_module_response_deframer smrd_checker u_smrd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_frame_byte (o_frame_byte),
    .o_byte_index (o_byte_index),
    .o_frame_end  (o_frame_end),
    .o_status     (o_status)
);

`default_nettype wire

// File: tb/sv/smrd_checker.sv
// Checker for the secure module response deframer: follows register writes,
// predicts each result from the byte transfers and compares the result transfers.
// Depends on smrd_pkg.
`timescale 1ns / 100ps

module smrd_frame_checker
    import smrd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Byte channel as seen at the block.
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    // Result channel as seen at the block.
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [BYTE_W-1:0]  i_frame_byte,
    input  logic [INDEX_W-1:0] i_byte_index,
    input  logic               i_frame_end,
    input  logic [2:0]         i_status,
    // Configuration port as seen at the block.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    // Verdict inputs for the top.
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0]  frame_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               frame_end;
        t_status            status;
    } t_frame_result;

    // Predicted configuration and deframer state.
    logic [POLL_W-1:0]      poll_limit;
    logic [LEN_LIMIT_W-1:0] length_limit;
    t_phase                 phase;
    logic [INDEX_W-1:0]     position;
    logic [BYTE_W-1:0]      length_high;
    logic [INDEX_W-1:0]     remaining;
    logic [BYTE_W-1:0]      running_xor;
    logic [POLL_W-1:0]      poll_count;

    t_frame_result expected_frame_results[$];

    initial o_fail_count = 0;

    task automatic flag_failure(input string msg);
        $error("%s", msg);
        o_fail_count++;
    endtask

    // Advance the predicted deframer by one received byte and queue its result.
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        logic [TOTAL_W-1:0] total;
        t_frame_result      r;
        bit                 emit;
        emit = 1'b1;
        r = '{frame_byte: b, byte_index: position, frame_end: 1'b0, status: ST_BUSY};
        case (phase)
            PH_HEADER: begin
                running_xor = running_xor ^ b;
                if (position == 2) begin
                    length_high = b;
                end
                if (position < 3) begin
                    position = position + 1'b1;
                end else begin
                    // The body holds the announced length plus the checksum byte.
                    total = TOTAL_W'({length_high, b}) + TOTAL_W'(1);
                    if (total < length_limit && total < BUFFER_BYTES) begin
                        remaining = total[INDEX_W-1:0];
                        position = INDEX_W'(4);
                        phase = PH_BODY;
                    end else begin
                        phase = PH_HUNT;
                        position = '0;
                        r.frame_end = 1'b1;
                        r.status = ST_BADLEN;
                    end
                end
            end
            PH_BODY: begin
                if (remaining <= 1) begin
                    // Last byte is the inverted XOR of every frame byte after the sync byte and before it.
                    phase = PH_HUNT;
                    position = '0;
                    remaining = '0;
                    r.frame_end = 1'b1;
                    if (b == ~running_xor) begin
                        poll_count = '0;
                        r.status = ST_OK;
                    end else begin
                        r.status = ST_CSUM;
                    end
                end else begin
                    running_xor = running_xor ^ b;
                    remaining = remaining - 1'b1;
                    position = position + 1'b1;
                end
            end
            default: begin
                phase = PH_HUNT;
                emit = 1'b0;
                if (b == SYNC_BYTE) begin
                    phase = PH_HEADER;
                    position = '0;
                    running_xor = '0;
                    length_high = '0;
                    remaining = '0;
                end else begin
                    poll_count = poll_count + 1'b1;
                    if (poll_count >= poll_limit) begin
                        poll_count = '0;
                        emit = 1'b1;
                        r = '{frame_byte: '0, byte_index: '0, frame_end: 1'b1,
                              status: ST_TIMEOUT};
                    end
                end
            end
        endcase
        if (emit) begin
            expected_frame_results.push_back(r);
        end
    endtask

    // Compare one result transfer with the oldest prediction.
    task automatic check_result();
        t_frame_result want;
        if (expected_frame_results.size() == 0) begin
            flag_failure($sformatf("unexpected result: frame_byte %0d byte_index %0d status %0d",
                                   i_frame_byte, i_byte_index, i_status));
        end else begin
            want = expected_frame_results.pop_front();
            if (i_frame_byte !== want.frame_byte) begin
                flag_failure($sformatf("frame_byte: expected %0d, actual %0d",
                                       want.frame_byte, i_frame_byte));
            end
            if (i_byte_index !== want.byte_index) begin
                flag_failure($sformatf("byte_index: expected %0d, actual %0d",
                                       want.byte_index, i_byte_index));
            end
            if (i_frame_end !== want.frame_end) begin
                flag_failure($sformatf("frame_end: expected %0d, actual %0d",
                                       want.frame_end, i_frame_end));
            end
            if (i_status !== want.status) begin
                flag_failure($sformatf("status: expected %0d, actual %0d",
                                       want.status, i_status));
            end
        end
    endtask

    // Watch all three ports at each rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            poll_limit = POLL_LIMIT_RESET;
            length_limit = LENGTH_LIMIT_RESET;
            phase = PH_HUNT;
            position = '0;
            length_high = '0;
            remaining = '0;
            running_xor = '0;
            poll_count = '0;
            expected_frame_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_index'(paddr[2]))
                    REG_POLL_LIMIT:   poll_limit = pwdata[POLL_W-1:0];
                    REG_LENGTH_LIMIT: length_limit = pwdata[LEN_LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
            if (i_in_valid && !i_in_stall) begin
                deframe_byte(i_rx_byte);
            end
        end
        o_pending <= expected_frame_results.size();
    end

endmodule

// File: tb/sv/testbench.sv
// Top of the deframer testbench: clock, reset, byte and register stimulus, verdict.
// Depends on smrd_pkg, secure_module_response_deframer and smrd_frame_checker.
`timescale 1ns / 100ps

module testbench
    import smrd_pkg::*;
();

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_BYTES = 340;
    localparam int SETTLE_CYCLES = 6;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [BYTE_W-1:0]  rx_byte = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [BYTE_W-1:0]  frame_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               frame_end;
    logic [2:0]         status;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int results_pending;
    int cycle_count = 0;
    int bytes_sent = 0;

    // Current length limit, used only to decide whether a frame body is worth sending.
    logic [LEN_LIMIT_W-1:0] length_cfg = LENGTH_LIMIT_RESET;
    bit steady_in = 1'b0;
    bit steady_out = 1'b0;

    secure_module_response_deframer dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_rx_byte    (rx_byte),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_frame_byte (frame_byte),
        .o_byte_index (byte_index),
        .o_frame_end  (frame_end),
        .o_status     (status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    smrd_frame_checker frame_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_rx_byte    (rx_byte),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_frame_byte (frame_byte),
        .i_byte_index (byte_index),
        .i_frame_end  (frame_end),
        .i_status     (status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    // 20 ns clock.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[secure_module_response_deframer] ERROR");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before each transfer.
    initial begin : result_stall
        int wait_cycles;
        forever begin
            wait_cycles = steady_out ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 39) == 0) begin
                steady_out = !steady_out;
            end
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // One byte transfer after a random idle gap; valid stays high between back-to-back bytes.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = steady_in ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // Sync, two random status bytes, the length field, then body and checksum.
    task automatic send_frame(input logic [15:0] len_field, input bit corrupt);
        logic [BYTE_W-1:0] csum;
        logic [BYTE_W-1:0] b;
        int unsigned       total;
        total = int'(len_field) + 1;
        csum = '0;
        send_byte(SYNC_BYTE);
        repeat (2) begin
            b = 8'($urandom);
            csum = csum ^ b;
            send_byte(b);
        end
        csum = csum ^ len_field[15:8] ^ len_field[7:0];
        send_byte(len_field[15:8]);
        send_byte(len_field[7:0]);
        // A rejected header puts the block back to hunting, so no body follows it.
        if (total < length_cfg && total < BUFFER_BYTES) begin
            repeat (total - 1) begin
                b = 8'($urandom);
                csum = csum ^ b;
                send_byte(b);
            end
            if (corrupt) begin
                send_byte(~csum ^ (8'h01 << $urandom_range(0, 7)));
            end else begin
                send_byte(~csum);
            end
        end
    endtask

    // Let every predicted result drain, plus the pipeline depth for bytes with no result.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, access cycle until pready, then the port is released.
    task automatic apb_write(input t_reg_index idx, input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Upper data bits are random; the block keeps only the register width.
    task automatic set_limits(input logic [POLL_W-1:0] poll,
                              input logic [LEN_LIMIT_W-1:0] len_limit);
        wait_drained();
        apb_write(REG_POLL_LIMIT, {16'($urandom), poll});
        apb_write(REG_LENGTH_LIMIT, {21'($urandom), len_limit});
        length_cfg = len_limit;
    endtask

    // Mostly well-formed frames with random content, plus noise, bad lengths and cut headers.
    task automatic run_random(input int count);
        int          stop_at;
        int          pick;
        logic [15:0] len_field;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                if (length_cfg >= 2 && length_cfg <= 64 && $urandom_range(0, 3) == 0) begin
                    len_field = 16'(length_cfg - 2);
                end else begin
                    len_field = 16'($urandom_range(0, 12));
                end
                send_frame(len_field, $urandom_range(0, 3) == 0);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end else if (pick < 95) begin
                case ($urandom_range(0, 2))
                    0: len_field = 16'(length_cfg) - 16'd1;
                    1: len_field = 16'(BUFFER_BYTES - 1);
                    default: len_field = 16'($urandom);
                endcase
                send_frame(len_field, 1'b0);
            end else begin
                // Header cut short: the next sync byte is taken as frame data.
                send_byte(SYNC_BYTE);
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
            if ($urandom_range(0, 7) == 0) begin
                steady_in = !steady_in;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset limits: idle bytes at both extremes, shortest good frame,
        // sync bytes used as frame data with a bad checksum, oversized length.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(16'd0, 1'b0);
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(SYNC_BYTE);
        send_byte(8'h00);
        send_frame(16'hFFFF, 1'b0);
        send_frame(16'd2, 1'b1);

        // Zero limits: every idle byte times out and every header is too long.
        set_limits(16'd0, 11'd0);
        send_byte(8'hAA);
        send_byte(8'h00);
        send_frame(16'd0, 1'b0);

        // Random traffic under several limit settings.
        set_limits(16'd7, 11'd40);
        run_random(RANDOM_BYTES / 6);
        set_limits(16'd1, 11'd2);
        run_random(RANDOM_BYTES / 6);
        set_limits(16'd65535, 11'd2047);
        run_random(RANDOM_BYTES / 6);
        set_limits(16'd25, 11'd1024);
        run_random(RANDOM_BYTES / 6);
        set_limits(16'd3, 11'd17);
        run_random(RANDOM_BYTES / 6);
        set_limits(16'd0, 11'd1);
        run_random(RANDOM_BYTES / 6);

        // A frame with a nonzero length high byte, then one length past the buffer.
        set_limits(16'd40000, 11'd2047);
        send_frame(16'd256, 1'b0);
        send_frame(16'd1023, 1'b0);
        send_frame(16'd3, 1'b1);

        wait_drained();
        if (fail_count == 0) begin
            $display("[secure_module_response_deframer] OK");
        end else begin
            $display("[secure_module_response_deframer] ERROR");
        end
        $finish;
    end

endmodule
